// ===== rtl/core/vcr_pkg.sv =====
// Package: shared constants, register indexes and ramp codes for the color ramp.
`timescale 1ns / 1ps
package vcr_pkg;

  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int CHANNEL_BITS_DEF = 8;
  // numerator head room over the sample width: 255 * 7 * D < 2^11 * 2^S
  localparam int NUM_EXTRA_BITS   = 11;
  localparam int INDEX_BITS       = 2;
  localparam int MAP_BITS         = 5;
  localparam int RANGE_HIGH_RESET = 65535;
  localparam int MAP_RESET        = 1;

  localparam logic [INDEX_BITS-1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [INDEX_BITS-1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [INDEX_BITS-1:0] REG_MAP_TYPE   = 2'd2;

  localparam logic [MAP_BITS-1:0] MAP_JET          = 5'd1;
  localparam logic [MAP_BITS-1:0] MAP_RED_BLUE     = 5'd2;
  localparam logic [MAP_BITS-1:0] MAP_GREY         = 5'd3;
  localparam logic [MAP_BITS-1:0] MAP_HUE          = 5'd4;
  localparam logic [MAP_BITS-1:0] MAP_GREEN_YELLOW = 5'd5;
  localparam logic [MAP_BITS-1:0] MAP_GREEN_MAG    = 5'd6;
  localparam logic [MAP_BITS-1:0] MAP_RAINBOW      = 5'd7;
  localparam logic [MAP_BITS-1:0] MAP_GREY_TENT    = 5'd8;
  localparam logic [MAP_BITS-1:0] MAP_RED_BLUE_TRI = 5'd9;
  localparam logic [MAP_BITS-1:0] MAP_JET_WHITE    = 5'd10;
  localparam logic [MAP_BITS-1:0] MAP_GRAD_BROWN   = 5'd11;
  localparam logic [MAP_BITS-1:0] MAP_GRAD_EARTH   = 5'd12;
  localparam logic [MAP_BITS-1:0] MAP_GRAD_FIRE    = 5'd13;
  localparam logic [MAP_BITS-1:0] MAP_RED_YELLOW   = 5'd14;
  localparam logic [MAP_BITS-1:0] MAP_JET_LIGHT    = 5'd15;
  localparam logic [MAP_BITS-1:0] MAP_BLUE_GREEN   = 5'd16;
  localparam logic [MAP_BITS-1:0] MAP_RED_CYAN     = 5'd17;
  localparam logic [MAP_BITS-1:0] MAP_BLUE_CYAN    = 5'd18;
  localparam logic [MAP_BITS-1:0] MAP_BLUE_WHITE   = 5'd19;
  localparam logic [MAP_BITS-1:0] MAP_GRAD_TERRAIN = 5'd20;
  localparam logic [MAP_BITS-1:0] MAP_GRAD_PALE    = 5'd21;
  localparam logic [MAP_BITS-1:0] MAP_YELLOW_BLUE  = 5'd22;
  localparam logic [MAP_BITS-1:0] MAP_RED_WHITE    = 5'd23;
  localparam logic [MAP_BITS-1:0] MAP_BLUE_YELLOW  = 5'd24;
  localparam logic [MAP_BITS-1:0] MAP_BLUE_RED     = 5'd25;

  // gradient stop colors, 8-bit fractions of full scale
  localparam int STOPS11 [2][3] = '{'{200, 60, 0}, '{250, 160, 110}};
  localparam int STOPS12 [3][3] = '{'{55, 55, 45}, '{235, 90, 30}, '{250, 160, 110}};
  localparam int STOPS13 [3][3] = '{'{0, 255, 0}, '{255, 150, 0}, '{255, 250, 240}};
  localparam int STOPS20 [3][3] = '{'{0, 160, 0}, '{180, 220, 0}, '{250, 220, 170}};
  localparam int STOPS21 [2][3] = '{'{255, 255, 200}, '{150, 150, 255}};
  localparam int STOP_SCALE = 255;

endpackage

// ===== rtl/core/vcr_if.sv =====
// Interfaces: sample request, color request and register write channels.
`timescale 1ns / 1ps
interface vcr_sample_if #(parameter int SAMPLE_BITS = vcr_pkg::SAMPLE_BITS_DEF);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface vcr_color_if #(parameter int CHANNEL_BITS = vcr_pkg::CHANNEL_BITS_DEF);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface vcr_cfg_if #(parameter int DATA_BITS = vcr_pkg::SAMPLE_BITS_DEF);
  logic                             valid;
  logic                             ready;
  logic [vcr_pkg::INDEX_BITS-1:0]   index;
  logic [DATA_BITS-1:0]             data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/vcr_ramp.sv =====
// Front end: range ordering, clamping and ramp numerator / denominator stages.
`timescale 1ns / 1ps
module vcr_ramp #(
  parameter int SAMPLE_BITS  = vcr_pkg::SAMPLE_BITS_DEF,
  parameter int CHANNEL_BITS = vcr_pkg::CHANNEL_BITS_DEF,
  parameter int NUM_BITS     = SAMPLE_BITS + vcr_pkg::NUM_EXTRA_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   up_valid,
  output logic                                   up_ready,
  input  logic [SAMPLE_BITS-1:0]                 sample,
  input  logic [SAMPLE_BITS-1:0]                 range_low,
  input  logic [SAMPLE_BITS-1:0]                 range_high,
  input  logic [vcr_pkg::MAP_BITS-1:0]           map_type,
  output logic                                   dn_valid,
  input  logic                                   dn_ready,
  output logic [2:0][NUM_BITS+CHANNEL_BITS-1:0]  rem,
  output logic [NUM_BITS-1:0]                    den
);

  localparam int REM_BITS = NUM_BITS + CHANNEL_BITS;
  typedef logic signed [NUM_BITS+1:0] wide_t;

  localparam wide_t K2 = 2;
  localparam wide_t K3 = 3;
  localparam wide_t K4 = 4;
  localparam wide_t K5 = 5;
  localparam wide_t K6 = 6;

  function automatic wide_t grad2(input int s0, input int s1, input wide_t t, input wide_t d);
    return wide_t'(s0) * d + wide_t'(s1 - s0) * t;
  endfunction

  function automatic wide_t grad3(input int s0, input int s1, input int s2, input int p,
                                  input int q, input logic lower, input wide_t t,
                                  input wide_t d);
    wide_t r;
    if (lower) begin
      r = wide_t'(s0 * p) * d + wide_t'((s1 - s0) * q) * t;
    end else begin
      r = wide_t'(s1 * (q - p)) * d + wide_t'(s2 - s1) * (wide_t'(q) * t - wide_t'(p) * d);
    end
    return r;
  endfunction

  // stage a: sample register
  logic                   va;
  logic [SAMPLE_BITS-1:0] sample_a;
  // stage b: offset and width
  logic                   vb;
  logic [SAMPLE_BITS-1:0] t_b;
  logic [SAMPLE_BITS-1:0] d_b;
  logic [vcr_pkg::MAP_BITS-1:0] map_b;
  logic                   rdy_a, rdy_b, rdy_c;

  assign rdy_c    = !dn_valid || dn_ready;
  assign rdy_b    = !vb || rdy_c;
  assign rdy_a    = !va || rdy_b;
  assign up_ready = rdy_a;

  // bound ordering and clamp
  logic [SAMPLE_BITS-1:0] lo, hi, vc, t_next, d_next;
  always_comb begin
    lo = (range_high < range_low) ? range_high : range_low;
    hi = (range_high < range_low) ? range_low : range_high;
    if (lo == hi) begin
      // empty range widened by one on each side
      d_next = SAMPLE_BITS'(2);
      vc     = '0;
      if (sample_a < lo) t_next = '0;
      else if (sample_a == lo) t_next = SAMPLE_BITS'(1);
      else t_next = SAMPLE_BITS'(2);
    end else begin
      vc     = (sample_a < lo) ? lo : ((sample_a > hi) ? hi : sample_a);
      t_next = vc - lo;
      d_next = hi - lo;
    end
  end

  // ramp selection
  wide_t t1, d1, t2, t3, t4, t5, t6, d2, d3, d4, d5, d6;
  wide_t n0, n1, n2, q_den;
  logic  low12, low13;
  always_comb begin
    t1 = wide_t'(t_b);
    d1 = wide_t'(d_b);
    t2 = K2 * t1; t3 = K3 * t1; t4 = K4 * t1; t5 = K5 * t1; t6 = K6 * t1;
    d2 = K2 * d1; d3 = K3 * d1; d4 = K4 * d1; d5 = K5 * d1; d6 = K6 * d1;
    low12 = (K5 * t1) < (K2 * d1);
    low13 = (wide_t'(10) * t1) < (K3 * d1);
    q_den = d1;
    n0 = d1; n1 = d1; n2 = d1;
    case (map_b)
      vcr_pkg::MAP_JET: begin
        if (t4 < d1) begin n0 = '0; n1 = t4; n2 = d1; end
        else if (t4 < d2) begin n0 = '0; n1 = d1; n2 = d2 - t4; end
        else if (t4 < d3) begin n0 = t4 - d2; n1 = d1; n2 = '0; end
        else begin n0 = d1; n1 = d4 - t4; n2 = '0; end
      end
      vcr_pkg::MAP_RED_BLUE: begin n0 = t1; n1 = '0; n2 = d1 - t1; end
      vcr_pkg::MAP_GREY: begin n0 = t1; n1 = t1; n2 = t1; end
      vcr_pkg::MAP_HUE: begin
        if (t6 < d1) begin n0 = d1; n1 = t6; n2 = '0; end
        else if (t6 < d2) begin n0 = d2 - t6; n1 = d1; n2 = '0; end
        else if (t6 < d3) begin n0 = '0; n1 = d1; n2 = t6 - d2; end
        else if (t6 < d4) begin n0 = '0; n1 = d4 - t6; n2 = d1; end
        else if (t6 < d5) begin n0 = t6 - d4; n1 = '0; n2 = d1; end
        else begin n0 = d1; n1 = '0; n2 = d6 - t6; end
      end
      vcr_pkg::MAP_GREEN_YELLOW: begin n0 = t1; n1 = d1; n2 = '0; end
      vcr_pkg::MAP_GREEN_MAG: begin n0 = t1; n1 = d1 - t1; n2 = t1; end
      vcr_pkg::MAP_RAINBOW: begin
        if (t4 < d1) begin n0 = '0; n1 = t4; n2 = d1 - t4; end
        else if (t4 < d2) begin n0 = t4 - d1; n1 = d2 - t4; n2 = '0; end
        else if (t4 < d3) begin n0 = d3 - t4; n1 = t4 - d2; n2 = '0; end
        else begin n0 = '0; n1 = d4 - t4; n2 = t4 - d3; end
      end
      vcr_pkg::MAP_GREY_TENT: begin
        if (t2 < d1) begin n0 = t2; n1 = t2; n2 = t2; end
        else begin n0 = d2 - t2; n1 = d2 - t2; n2 = d2 - t2; end
      end
      vcr_pkg::MAP_RED_BLUE_TRI: begin
        if (t3 < d1) begin n0 = d1 - t3; n1 = '0; n2 = t3; end
        else if (t3 < d2) begin n0 = '0; n1 = t3 - d1; n2 = d1; end
        else begin n0 = t3 - d2; n1 = d3 - t3; n2 = d1; end
      end
      vcr_pkg::MAP_JET_WHITE: begin
        if (t5 < d1) begin n0 = '0; n1 = t5; n2 = d1; end
        else if (t5 < d2) begin n0 = '0; n1 = d1; n2 = d2 - t5; end
        else if (t5 < d3) begin n0 = t5 - d2; n1 = d1; n2 = '0; end
        else if (t5 < d4) begin n0 = d1; n1 = d4 - t5; n2 = '0; end
        else begin n0 = d1; n1 = t5 - d4; n2 = t5 - d4; end
      end
      vcr_pkg::MAP_GRAD_BROWN: begin
        n0 = grad2(vcr_pkg::STOPS11[0][0], vcr_pkg::STOPS11[1][0], t1, d1);
        n1 = grad2(vcr_pkg::STOPS11[0][1], vcr_pkg::STOPS11[1][1], t1, d1);
        n2 = grad2(vcr_pkg::STOPS11[0][2], vcr_pkg::STOPS11[1][2], t1, d1);
        q_den = wide_t'(vcr_pkg::STOP_SCALE) * d1;
      end
      vcr_pkg::MAP_GRAD_EARTH: begin
        n0 = grad3(vcr_pkg::STOPS12[0][0], vcr_pkg::STOPS12[1][0], vcr_pkg::STOPS12[2][0],
                   2, 5, low12, t1, d1);
        n1 = grad3(vcr_pkg::STOPS12[0][1], vcr_pkg::STOPS12[1][1], vcr_pkg::STOPS12[2][1],
                   2, 5, low12, t1, d1);
        n2 = grad3(vcr_pkg::STOPS12[0][2], vcr_pkg::STOPS12[1][2], vcr_pkg::STOPS12[2][2],
                   2, 5, low12, t1, d1);
        q_den = wide_t'(vcr_pkg::STOP_SCALE * (low12 ? 2 : 3)) * d1;
      end
      vcr_pkg::MAP_GRAD_FIRE: begin
        n0 = grad3(vcr_pkg::STOPS13[0][0], vcr_pkg::STOPS13[1][0], vcr_pkg::STOPS13[2][0],
                   3, 10, low13, t1, d1);
        n1 = grad3(vcr_pkg::STOPS13[0][1], vcr_pkg::STOPS13[1][1], vcr_pkg::STOPS13[2][1],
                   3, 10, low13, t1, d1);
        n2 = grad3(vcr_pkg::STOPS13[0][2], vcr_pkg::STOPS13[1][2], vcr_pkg::STOPS13[2][2],
                   3, 10, low13, t1, d1);
        q_den = wide_t'(vcr_pkg::STOP_SCALE * (low13 ? 3 : 7)) * d1;
      end
      vcr_pkg::MAP_RED_YELLOW: begin n0 = d1; n1 = d1 - t1; n2 = '0; end
      vcr_pkg::MAP_JET_LIGHT: begin
        if (t4 < d1) begin n0 = '0; n1 = t4; n2 = d1; end
        else if (t4 < d2) begin n0 = '0; n1 = d1; n2 = d2 - t4; end
        else if (t4 < d3) begin n0 = t4 - d2; n1 = d1; n2 = '0; end
        else begin n0 = d1; n1 = d1; n2 = t4 - d3; end
      end
      vcr_pkg::MAP_BLUE_GREEN: begin
        if (t2 < d1) begin n0 = '0; n1 = t2; n2 = d1 - t2; end
        else begin n0 = t2 - d1; n1 = d2 - t2; n2 = '0; end
      end
      vcr_pkg::MAP_RED_CYAN: begin
        if (t2 < d1) begin n0 = d1; n1 = d1 - t2; n2 = t2; end
        else begin n0 = d2 - t2; n1 = t2 - d1; n2 = d1; end
      end
      vcr_pkg::MAP_BLUE_CYAN: begin n0 = '0; n1 = t1; n2 = d1; end
      vcr_pkg::MAP_BLUE_WHITE: begin n0 = t1; n1 = t1; n2 = d1; end
      vcr_pkg::MAP_GRAD_TERRAIN: begin
        n0 = grad3(vcr_pkg::STOPS20[0][0], vcr_pkg::STOPS20[1][0], vcr_pkg::STOPS20[2][0],
                   3, 10, low13, t1, d1);
        n1 = grad3(vcr_pkg::STOPS20[0][1], vcr_pkg::STOPS20[1][1], vcr_pkg::STOPS20[2][1],
                   3, 10, low13, t1, d1);
        n2 = grad3(vcr_pkg::STOPS20[0][2], vcr_pkg::STOPS20[1][2], vcr_pkg::STOPS20[2][2],
                   3, 10, low13, t1, d1);
        q_den = wide_t'(vcr_pkg::STOP_SCALE * (low13 ? 3 : 7)) * d1;
      end
      vcr_pkg::MAP_GRAD_PALE: begin
        n0 = grad2(vcr_pkg::STOPS21[0][0], vcr_pkg::STOPS21[1][0], t1, d1);
        n1 = grad2(vcr_pkg::STOPS21[0][1], vcr_pkg::STOPS21[1][1], t1, d1);
        n2 = grad2(vcr_pkg::STOPS21[0][2], vcr_pkg::STOPS21[1][2], t1, d1);
        q_den = wide_t'(vcr_pkg::STOP_SCALE) * d1;
      end
      vcr_pkg::MAP_YELLOW_BLUE: begin n0 = d1 - t1; n1 = d1 - t1; n2 = t1; end
      vcr_pkg::MAP_RED_WHITE: begin
        if (t2 < d1) begin n0 = d1; n1 = t2; n2 = t2; end
        else begin n0 = d2 - t2; n1 = d2 - t2; n2 = d1; end
      end
      vcr_pkg::MAP_BLUE_YELLOW: begin
        if (t2 < d1) begin n0 = t2; n1 = t2; n2 = d1 - t2; end
        else begin n0 = d1; n1 = d2 - t2; n2 = '0; end
      end
      vcr_pkg::MAP_BLUE_RED: begin
        if (t3 < d1) begin n0 = '0; n1 = t3; n2 = d1; end
        else if (t3 < d2) begin n0 = t3 - d1; n1 = d2 - t3; n2 = d1; end
        else begin n0 = d1; n1 = '0; n2 = d3 - t3; end
      end
      default: begin n0 = d1; n1 = d1; n2 = d1; end  // unknown ramp: white
    endcase
  end

  // numerator scaled to full channel scale: n * (2^C - 1)
  function automatic logic [REM_BITS-1:0] scale(input wide_t n);
    logic [REM_BITS-1:0] x;
    x = REM_BITS'(n[NUM_BITS-1:0]);
    return (x << CHANNEL_BITS) - x;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      va       <= 1'b0;
      vb       <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (rdy_a) va <= up_valid;
      if (rdy_b) vb <= va;
      if (rdy_c) dn_valid <= vb;
    end
    if (rdy_a && up_valid) sample_a <= sample;
    if (rdy_b && va) begin
      t_b   <= t_next;
      d_b   <= d_next;
      map_b <= map_type;
    end
    if (rdy_c && vb) begin
      rem[0] <= scale(n0);
      rem[1] <= scale(n1);
      rem[2] <= scale(n2);
      den    <= q_den[NUM_BITS-1:0];
    end
  end

endmodule

// ===== rtl/core/vcr_div_cell.sv =====
// Divider cell: one quotient bit for all three channels, registered.
`timescale 1ns / 1ps
module vcr_div_cell #(
  parameter int NUM_BITS     = vcr_pkg::SAMPLE_BITS_DEF + vcr_pkg::NUM_EXTRA_BITS,
  parameter int CHANNEL_BITS = vcr_pkg::CHANNEL_BITS_DEF,
  parameter int BIT          = 0
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  up_valid,
  output logic                                  up_ready,
  input  logic [2:0][NUM_BITS+CHANNEL_BITS-1:0] rem_in,
  input  logic [NUM_BITS-1:0]                   den_in,
  input  logic [2:0][CHANNEL_BITS-1:0]          quo_in,
  output logic                                  dn_valid,
  input  logic                                  dn_ready,
  output logic [2:0][NUM_BITS+CHANNEL_BITS-1:0] rem_out,
  output logic [NUM_BITS-1:0]                   den_out,
  output logic [2:0][CHANNEL_BITS-1:0]          quo_out
);

  localparam int REM_BITS = NUM_BITS + CHANNEL_BITS;

  logic [REM_BITS-1:0] shifted;
  logic [2:0][REM_BITS-1:0] rem_next;
  logic [2:0][CHANNEL_BITS-1:0] quo_next;

  assign up_ready = !dn_valid || dn_ready;
  assign shifted  = REM_BITS'(den_in) << BIT;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_next[i] = rem_in[i];
      quo_next[i] = quo_in[i];
      if (rem_in[i] >= shifted) begin
        rem_next[i]      = rem_in[i] - shifted;
        quo_next[i][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      rem_out <= rem_next;
      den_out <= den_in;
      quo_out <= quo_next;
    end
  end

endmodule

// ===== rtl/core/value_to_color_ramp.sv =====
// Top level: pseudocolor ramp, sample in, RGB out, with register write port.
//
//   channel  dir  fields                    accepted when
//   pixel    in   sample                    pixel.valid && pixel.ready
//   color    out  red, green, blue          color.valid && color.ready
//   cfg      in   index, data               cfg.valid && cfg.ready (always ready)
//
// One request per clock while the output is not stalled. The stages are the sample
// register, range/clamp stage, ramp numerator stage, then one divider cell per
// output bit, the last cell being the output register.
// Each stage holds its own valid and moves on when the next one is empty or
// moving, so bubbles close up and input stays open while a result waits, until every stage is full.
// Synchronous reset clears all valids and loads the register defaults.
`timescale 1ns / 1ps
module value_to_color_ramp #(
  parameter int SAMPLE_BITS  = vcr_pkg::SAMPLE_BITS_DEF,
  parameter int CHANNEL_BITS = vcr_pkg::CHANNEL_BITS_DEF
) (
  input logic           clk,
  input logic           rst,
  vcr_sample_if.sink    pixel,
  vcr_color_if.source   color,
  vcr_cfg_if.sink       cfg
);

  localparam int NUM_BITS = SAMPLE_BITS + vcr_pkg::NUM_EXTRA_BITS;
  localparam int REM_BITS = NUM_BITS + CHANNEL_BITS;

  // configuration registers
  logic [SAMPLE_BITS-1:0]       range_low;
  logic [SAMPLE_BITS-1:0]       range_high;
  logic [vcr_pkg::MAP_BITS-1:0] map_type;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= '0;
      range_high <= SAMPLE_BITS'(vcr_pkg::RANGE_HIGH_RESET);
      map_type   <= vcr_pkg::MAP_BITS'(vcr_pkg::MAP_RESET);
    end else if (cfg.valid) begin
      case (cfg.index)
        vcr_pkg::REG_RANGE_LOW:  range_low  <= cfg.data[SAMPLE_BITS-1:0];
        vcr_pkg::REG_RANGE_HIGH: range_high <= cfg.data[SAMPLE_BITS-1:0];
        vcr_pkg::REG_MAP_TYPE:   map_type   <= cfg.data[vcr_pkg::MAP_BITS-1:0];
        default: ;  // index beyond the list: dropped
      endcase
    end
  end

  // divider chain links; link 0 is fed by the ramp front end
  logic                          valid_c [CHANNEL_BITS+1];
  logic                          ready_c [CHANNEL_BITS+1];
  logic [2:0][REM_BITS-1:0]      rem_c   [CHANNEL_BITS+1];
  logic [NUM_BITS-1:0]           den_c   [CHANNEL_BITS+1];
  logic [2:0][CHANNEL_BITS-1:0]  quo_c   [CHANNEL_BITS+1];

  vcr_ramp #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .CHANNEL_BITS (CHANNEL_BITS),
    .NUM_BITS     (NUM_BITS)
  ) u_ramp (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (pixel.valid),
    .up_ready   (pixel.ready),
    .sample     (pixel.sample),
    .range_low  (range_low),
    .range_high (range_high),
    .map_type   (map_type),
    .dn_valid   (valid_c[0]),
    .dn_ready   (ready_c[0]),
    .rem        (rem_c[0]),
    .den        (den_c[0])
  );

  assign quo_c[0] = '0;

  // restoring division, most significant quotient bit first
  for (genvar k = 0; k < CHANNEL_BITS; k++) begin : g_cell
    vcr_div_cell #(
      .NUM_BITS     (NUM_BITS),
      .CHANNEL_BITS (CHANNEL_BITS),
      .BIT          (CHANNEL_BITS - 1 - k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (valid_c[k]),
      .up_ready (ready_c[k]),
      .rem_in   (rem_c[k]),
      .den_in   (den_c[k]),
      .quo_in   (quo_c[k]),
      .dn_valid (valid_c[k+1]),
      .dn_ready (ready_c[k+1]),
      .rem_out  (rem_c[k+1]),
      .den_out  (den_c[k+1]),
      .quo_out  (quo_c[k+1])
    );
  end

  assign color.valid            = valid_c[CHANNEL_BITS];
  assign ready_c[CHANNEL_BITS]  = color.ready;
  assign color.red              = quo_c[CHANNEL_BITS][0];
  assign color.green            = quo_c[CHANNEL_BITS][1];
  assign color.blue             = quo_c[CHANNEL_BITS][2];

endmodule

// ===== tb/tb_top.sv =====
// Testbench: random and directed samples through the color ramp, scoreboarded per channel.
`timescale 1ns / 1ps

typedef struct packed {
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
} rgb_t;

// Expected colors, oldest first, and the running error count.
class ramp_scoreboard;
  rgb_t        pending[$];
  int unsigned errors;
  int unsigned checked;

  function void note_sample(rgb_t c);
    pending.push_back(c);
  endfunction

  task report(string what);
    $display("%0t mismatch: %s", $realtime, what);
    errors++;
  endtask

  task check_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    rgb_t e;
    if (pending.size() == 0) begin
      report($sformatf("color %0d/%0d/%0d with nothing pending", r, g, b));
      return;
    end
    e = pending.pop_front();
    checked++;
    if (r !== e.red) report($sformatf("red %0d, expected %0d", r, e.red));
    if (g !== e.green) report($sformatf("green %0d, expected %0d", g, e.green));
    if (b !== e.blue) report($sformatf("blue %0d, expected %0d", b, e.blue));
  endtask
endclass

module tb_top;

  localparam int LATENCY  = 3 + vcr_pkg::CHANNEL_BITS_DEF;
  localparam int WATCHDOG = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  vcr_sample_if pixel ();
  vcr_color_if  color ();
  vcr_cfg_if    cfg ();

  value_to_color_ramp i_dut (
    .clk  (clk),
    .rst  (rst),
    .pixel(pixel.sink),
    .color(color.source),
    .cfg  (cfg.sink)
  );

  ramp_scoreboard sb = new();

  // Predictor copy of the registers.
  logic [15:0] lo_reg = 16'd0;
  logic [15:0] hi_reg = 16'hffff;
  logic [4:0]  map_reg = 5'(vcr_pkg::MAP_RESET);

  // Idle percentages; the stall process also honors a long hold-off.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_off = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned cfg_writes = 0;
  int unsigned samples_sent = 0;

  // Directed sample points.
  int ramp_pts [10] = '{0, 100, 125, 130, 140, 150, 160, 175, 200, 65535};
  int rev_pts  [5]  = '{0, 1, 32768, 65534, 65535};
  int flat_pts [3]  = '{0, 777, 65535};

  // Exact channel value: floor(clamp(n/d) * 255).
  function automatic logic [7:0] chan_value(longint n, longint d);
    if (d <= 0) return 8'hff;
    if (n < 0) n = 0;
    if (n > d) n = d;
    return 8'((n * 255) / d);
  endfunction

  // Two-stop gradient numerators in 255ths.
  function automatic void grad_two(input int s[2][3], input longint t, input longint d,
                                   output longint n[3], output longint q);
    for (int i = 0; i < 3; i++) n[i] = s[0][i] * d + (s[1][i] - s[0][i]) * t;
    q = 255 * d;
  endfunction

  // Three stops, middle stop at p/qq of the range.
  function automatic void grad_three(input int s[3][3], input longint p, input longint qq,
                                     input longint t, input longint d,
                                     output longint n[3], output longint q);
    if (qq * t < p * d) begin
      for (int i = 0; i < 3; i++) n[i] = s[0][i] * p * d + (s[1][i] - s[0][i]) * qq * t;
      q = 255 * p * d;
    end else begin
      for (int i = 0; i < 3; i++)
        n[i] = s[1][i] * (qq - p) * d + (s[2][i] - s[1][i]) * (qq * t - p * d);
      q = 255 * (qq - p) * d;
    end
  endfunction

  function automatic rgb_t ramp_color(logic [15:0] smp);
    longint lo, hi, v, t, d, q, sw;
    longint n[3];
    rgb_t c;
    lo = lo_reg;
    hi = hi_reg;
    v  = smp;
    // reversed bounds swap; equal bounds widen by one each side
    if (hi < lo) begin
      sw = lo; lo = hi; hi = sw;
    end
    if (hi == lo) begin
      lo -= 1; hi += 1;
    end
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    t = v - lo;
    d = hi - lo;
    q = d;
    case (map_reg)
      vcr_pkg::MAP_JET:
        if (4*t < d) n = '{0, 4*t, d};
        else if (4*t < 2*d) n = '{0, d, 2*d - 4*t};
        else if (4*t < 3*d) n = '{4*t - 2*d, d, 0};
        else n = '{d, 4*d - 4*t, 0};
      vcr_pkg::MAP_RED_BLUE: n = '{t, 0, d - t};
      vcr_pkg::MAP_GREY: n = '{t, t, t};
      vcr_pkg::MAP_HUE:
        if (6*t < d) n = '{d, 6*t, 0};
        else if (6*t < 2*d) n = '{2*d - 6*t, d, 0};
        else if (6*t < 3*d) n = '{0, d, 6*t - 2*d};
        else if (6*t < 4*d) n = '{0, 4*d - 6*t, d};
        else if (6*t < 5*d) n = '{6*t - 4*d, 0, d};
        else n = '{d, 0, 6*d - 6*t};
      vcr_pkg::MAP_GREEN_YELLOW: n = '{t, d, 0};
      vcr_pkg::MAP_GREEN_MAG: n = '{t, d - t, t};
      vcr_pkg::MAP_RAINBOW:
        if (4*t < d) n = '{0, 4*t, d - 4*t};
        else if (4*t < 2*d) n = '{4*t - d, 2*d - 4*t, 0};
        else if (4*t < 3*d) n = '{3*d - 4*t, 4*t - 2*d, 0};
        else n = '{0, 4*d - 4*t, 4*t - 3*d};
      vcr_pkg::MAP_GREY_TENT:
        if (2*t < d) n = '{2*t, 2*t, 2*t};
        else n = '{2*d - 2*t, 2*d - 2*t, 2*d - 2*t};
      vcr_pkg::MAP_RED_BLUE_TRI:
        if (3*t < d) n = '{d - 3*t, 0, 3*t};
        else if (3*t < 2*d) n = '{0, 3*t - d, d};
        else n = '{3*t - 2*d, 3*d - 3*t, d};
      vcr_pkg::MAP_JET_WHITE:
        if (5*t < d) n = '{0, 5*t, d};
        else if (5*t < 2*d) n = '{0, d, 2*d - 5*t};
        else if (5*t < 3*d) n = '{5*t - 2*d, d, 0};
        else if (5*t < 4*d) n = '{d, 4*d - 5*t, 0};
        else n = '{d, 5*t - 4*d, 5*t - 4*d};
      vcr_pkg::MAP_GRAD_BROWN: grad_two(vcr_pkg::STOPS11, t, d, n, q);
      vcr_pkg::MAP_GRAD_EARTH: grad_three(vcr_pkg::STOPS12, 2, 5, t, d, n, q);
      vcr_pkg::MAP_GRAD_FIRE: grad_three(vcr_pkg::STOPS13, 3, 10, t, d, n, q);
      vcr_pkg::MAP_RED_YELLOW: n = '{d, d - t, 0};
      vcr_pkg::MAP_JET_LIGHT:
        if (4*t < d) n = '{0, 4*t, d};
        else if (4*t < 2*d) n = '{0, d, 2*d - 4*t};
        else if (4*t < 3*d) n = '{4*t - 2*d, d, 0};
        else n = '{d, d, 4*t - 3*d};
      vcr_pkg::MAP_BLUE_GREEN:
        if (2*t < d) n = '{0, 2*t, d - 2*t};
        else n = '{2*t - d, 2*d - 2*t, 0};
      vcr_pkg::MAP_RED_CYAN:
        if (2*t < d) n = '{d, d - 2*t, 2*t};
        else n = '{2*d - 2*t, 2*t - d, d};
      vcr_pkg::MAP_BLUE_CYAN: n = '{0, t, d};
      vcr_pkg::MAP_BLUE_WHITE: n = '{t, t, d};
      vcr_pkg::MAP_GRAD_TERRAIN: grad_three(vcr_pkg::STOPS20, 3, 10, t, d, n, q);
      vcr_pkg::MAP_GRAD_PALE: grad_two(vcr_pkg::STOPS21, t, d, n, q);
      vcr_pkg::MAP_YELLOW_BLUE: n = '{d - t, d - t, t};
      vcr_pkg::MAP_RED_WHITE:
        if (2*t < d) n = '{d, 2*t, 2*t};
        else n = '{2*d - 2*t, 2*d - 2*t, d};
      vcr_pkg::MAP_BLUE_YELLOW:
        if (2*t < d) n = '{2*t, 2*t, d - 2*t};
        else n = '{d, 2*d - 2*t, 0};
      vcr_pkg::MAP_BLUE_RED:
        if (3*t < d) n = '{0, 3*t, d};
        else if (3*t < 2*d) n = '{3*t - d, 2*d - 3*t, d};
        else n = '{d, 0, 3*d - 3*t};
      default: n = '{d, d, d};  // unknown ramp: white
    endcase
    c.red   = chan_value(n[0], q);
    c.green = chan_value(n[1], q);
    c.blue  = chan_value(n[2], q);
    return c;
  endfunction

  // Register write; only issued while nothing is in flight.
  task automatic write_reg(logic [vcr_pkg::INDEX_BITS-1:0] idx, logic [15:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      vcr_pkg::REG_RANGE_LOW:  lo_reg = val;
      vcr_pkg::REG_RANGE_HIGH: hi_reg = val;
      vcr_pkg::REG_MAP_TYPE:   map_reg = val[4:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_ramp(logic [15:0] lo, logic [15:0] hi, logic [4:0] map);
    write_reg(vcr_pkg::REG_RANGE_LOW, lo);
    write_reg(vcr_pkg::REG_RANGE_HIGH, hi);
    write_reg(vcr_pkg::REG_MAP_TYPE, {11'd0, map});
  endtask

  // One sample request; valid stays high across back-to-back requests.
  task automatic send_sample(logic [15:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel.valid <= 1'b0;
      @(posedge clk);
    end
    pixel.valid  <= 1'b1;
    pixel.sample <= smp;
    do @(posedge clk); while (!pixel.ready);
    sb.note_sample(ramp_color(smp));
    samples_sent++;
  endtask

  task automatic end_burst();
    pixel.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until the pipeline has drained, then let it settle.
  task automatic drain();
    end_burst();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Sample near the interesting points of the current range.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7))
      0: return lo_reg;
      1: return hi_reg;
      2: return 16'(lo_reg + $urandom_range(3));
      3: return 16'(hi_reg - $urandom_range(3));
      default: return 16'($urandom_range(16'hffff));
    endcase
  endfunction

  function automatic logic [15:0] pick_bound();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'($urandom_range(15));
      default: return 16'($urandom_range(16'hffff));
    endcase
  endfunction

  // Receiver: random stalls, or a long hold-off when asked.
  always @(posedge clk) begin
    if (rst || hold_off) begin
      color.ready <= 1'b0;
    end else begin
      color.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && color.valid && color.ready) begin
      sb.check_color(color.red, color.green, color.blue);
    end
  end

  // Watchdog: cycles with no request accepted on any channel.
  always @(posedge clk) begin
    if (rst || (pixel.valid && pixel.ready) || (color.valid && color.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog expired, %0d colors pending", sb.pending.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] lo, hi;
    pixel.valid  <= 1'b0;
    pixel.sample <= '0;
    cfg.valid    <= 1'b0;
    cfg.index    <= vcr_pkg::REG_RANGE_LOW;
    cfg.data     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every ramp across a small range, plus the special ranges.
    set_ramp(16'd100, 16'd200, vcr_pkg::MAP_JET);
    for (int m = 0; m <= 31; m++) begin
      write_reg(vcr_pkg::REG_MAP_TYPE, 16'(m));
      foreach (ramp_pts[k])
        send_sample(16'(ramp_pts[k]));
      drain();
    end
    // reversed bounds
    set_ramp(16'hffff, 16'd0, vcr_pkg::MAP_HUE);
    foreach (rev_pts[k])
      send_sample(16'(rev_pts[k]));
    drain();
    // equal bounds, including both ends of the scale
    foreach (flat_pts[b]) begin
      set_ramp(16'(flat_pts[b]), 16'(flat_pts[b]), vcr_pkg::MAP_JET);
      send_sample(16'd0);
      send_sample(16'(flat_pts[b]));
      send_sample(16'hffff);
      drain();
    end

    // Random phases with each idling mix, register set changed between phases.
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      lo = pick_bound();
      hi = pick_bound();
      set_ramp(lo, hi, 5'($urandom_range(31)));
      for (int i = 0; i < 84; i++) begin
        if (i % 25 == 0) write_reg(vcr_pkg::REG_MAP_TYPE, 16'($urandom_range(31)));
        send_sample(pick_sample());
        // mid-burst map change needs an empty pipe
        if (i % 25 == 24) drain();
      end
      drain();
    end

    // Back pressure: receiver holds off while the sender keeps offering.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_ramp(16'd1000, 16'd50000, vcr_pkg::MAP_GRAD_EARTH);
    fork
      begin
        hold_off <= 1'b1;
        repeat (60) @(posedge clk);
        hold_off <= 1'b0;
      end
      for (int i = 0; i < 40; i++) send_sample(pick_sample());
    join
    drain();

    $display("covered %0d samples and %0d register writes over all 32 map codes,",
             samples_sent, cfg_writes);
    $display("reversed and empty ranges, clamping, idle mixes and a long output stall");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/vcr_pkg.sv
rtl/core/vcr_if.sv
rtl/core/vcr_ramp.sv
rtl/core/vcr_div_cell.sv
rtl/core/value_to_color_ramp.sv
tb/tb_top.sv
